/* design/fixed_huffman_symbol_decoder_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the fixed Huffman symbol decoder
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef FIXED_HUFFMAN_SYMBOL_DECODER_ASSERT_SVH
`define FIXED_HUFFMAN_SYMBOL_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// expression must hold at every clock edge outside reset
`define FHSD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fhsd assertion failed");

// antecedent implies consequent in the same cycle
`define FHSD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fhsd assertion failed");

// antecedent implies consequent in the next cycle
`define FHSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fhsd assertion failed");

`else

`define FHSD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define FHSD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define FHSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/fhsd_pkg.sv */
// ---------------------------------------------------------------------------
// fhsd_pkg
// Commands, status codes, item types and the length-code table.
// ---------------------------------------------------------------------------
`default_nettype none

package fhsd_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH     = 2'd0,
      CMD_DECODE   = 2'd1,
      CMD_READ_LSB = 2'd2,
      CMD_READ_MSB = 2'd3
   } fhsd_cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NEED_BITS = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_INVALID   = 2'd3
   } fhsd_status_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic [4:0] bit_count;
   } fhsd_item_type;

   typedef struct packed {
      fhsd_status_type status;
      logic [15:0]     result_value;
      logic [8:0]      match_length;
   } fhsd_result_type;

   typedef struct packed {
      logic [8:0] base;
      logic [2:0] nextra;
   } fhsd_len_type;

   // code thresholds of the fixed literal/length code (first bit is MSB)
   localparam logic [6:0] CODE7_LIMIT     = 7'd24;
   localparam logic [7:0] CODE8_LIT_LIMIT = 8'd192;
   localparam logic [7:0] CODE8_LEN_LIMIT = 8'd200;

   localparam logic [8:0] SYM_END_OF_BLOCK  = 9'd256;
   localparam logic [8:0] SYM_FIRST_LENGTH  = 9'd257;
   localparam logic [8:0] SYM_FIRST_INVALID = 9'd286;

   localparam logic [3:0] CODE_LEN_7 = 4'd7;
   localparam logic [3:0] CODE_LEN_8 = 4'd8;
   localparam logic [3:0] CODE_LEN_9 = 4'd9;

   localparam logic [4:0] MAX_RAW_BITS = 5'd16;
   localparam logic [8:0] MAX_MATCH    = 9'd258;

   // base length and extra-bit count for length symbols 257..285,
   // indexed by symbol minus 257
   function automatic fhsd_len_type fhsd_len_info(input logic [4:0] idx);
      fhsd_len_type r;
      logic [8:0]   i9;
      i9 = {4'b0, idx};
      if (idx == 5'd28) begin
         r.base = MAX_MATCH;              r.nextra = 3'd0;
      end else if (idx < 5'd8) begin
         r.base = i9 + 9'd3;              r.nextra = 3'd0;
      end else if (idx < 5'd12) begin
         r.base = 9'd11 + ((i9 - 9'd8) << 1);   r.nextra = 3'd1;
      end else if (idx < 5'd16) begin
         r.base = 9'd19 + ((i9 - 9'd12) << 2);  r.nextra = 3'd2;
      end else if (idx < 5'd20) begin
         r.base = 9'd35 + ((i9 - 9'd16) << 3);  r.nextra = 3'd3;
      end else if (idx < 5'd24) begin
         r.base = 9'd67 + ((i9 - 9'd20) << 4);  r.nextra = 3'd4;
      end else begin
         r.base = 9'd131 + ((i9 - 9'd24) << 5); r.nextra = 3'd5;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/fhsd_if.sv */
// ---------------------------------------------------------------------------
// fhsd_req_if / fhsd_rsp_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface fhsd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   logic [4:0] bit_count;

   modport source (output valid, output cmd, output data_byte, output bit_count,
                   input ready);
   modport sink   (input valid, input cmd, input data_byte, input bit_count,
                   output ready);
endinterface

interface fhsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] result_value;
   logic [8:0]  match_length;
   logic [5:0]  bits_held;

   modport source (output valid, output status, output result_value,
                   output match_length, output bits_held, input ready);
   modport sink   (input valid, input status, input result_value,
                   input match_length, input bits_held, output ready);
endinterface

`default_nettype wire

/* design/fhsd_core.sv */
// ---------------------------------------------------------------------------
// fhsd_core
// Single-pass command logic: push, symbol decode, raw reads, next buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module fhsd_core
   import fhsd_pkg::*;
#(
   parameter int BUFFER_BITS = 32
) (
   input  fhsd_item_type                            item,
   input  logic [BUFFER_BITS-1:0]                   buf_cur,
   input  logic [$clog2(BUFFER_BITS+1)-1:0]         fill_cur,
   output fhsd_result_type                          result,
   output logic [BUFFER_BITS-1:0]                   buf_in,
   output logic [$clog2(BUFFER_BITS+1)-1:0]         fill_in
);

   localparam int FILL_W = $clog2(BUFFER_BITS+1);
   localparam logic [FILL_W-1:0] PUSH_LIMIT = FILL_W'(BUFFER_BITS - 8);

   fhsd_cmd_type      cmd_e;
   logic [8:0]        rev9;
   logic [15:0]       rev16;
   logic [6:0]        code7;
   logic [7:0]        code8;
   logic [4:0]        cnt;
   logic [16:0]       mask17;
   logic [15:0]       raw_lsb;
   logic [15:0]       raw_msb;
   logic [3:0]        code_len;
   logic [8:0]        sym;
   fhsd_len_type      len;
   logic [4:0]        need;
   logic [4:0]        extra;
   logic [4:0]        take_n;
   logic              push_ok;

   assign cmd_e = fhsd_cmd_type'(item.cmd);

   // stream order with the first bit as MSB
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rev9[8-i] = buf_cur[i];
      end
      for (int i = 0; i < 16; i++) begin
         rev16[15-i] = buf_cur[i];
      end
   end

   assign code7 = rev9[8:2];
   assign code8 = rev9[8:1];

   assign cnt     = (item.bit_count > MAX_RAW_BITS) ? MAX_RAW_BITS : item.bit_count;
   assign mask17  = (17'd1 << cnt) - 17'd1;
   assign raw_lsb = buf_cur[15:0] & mask17[15:0];
   assign raw_msb = rev16 >> (MAX_RAW_BITS - cnt);

   // match the code against the 7-, 8- and 9-bit ranges
   always_comb begin
      code_len = 4'd0;
      sym      = 9'd0;
      if (fill_cur >= FILL_W'(7)) begin
         if (code7 < CODE7_LIMIT) begin
            code_len = CODE_LEN_7;
            sym      = {2'b0, code7} + 9'd256;
         end else if (fill_cur >= FILL_W'(8)) begin
            if (code8 < CODE8_LIT_LIMIT) begin
               code_len = CODE_LEN_8;
               sym      = {1'b0, code8} - 9'd48;
            end else if (code8 < CODE8_LEN_LIMIT) begin
               code_len = CODE_LEN_8;
               sym      = {1'b0, code8} + 9'd88;
            end else if (fill_cur >= FILL_W'(9)) begin
               code_len = CODE_LEN_9;
               sym      = rev9 - 9'd256;
            end
         end
      end
   end

   assign len   = fhsd_len_info(5'(sym - SYM_FIRST_LENGTH));
   assign need  = {1'b0, code_len} + {2'b0, len.nextra};
   // length codes are 7 or 8 bits long; extra bits follow straight after
   assign extra = ((code_len == CODE_LEN_7) ? buf_cur[11:7] : buf_cur[12:8])
                  & ~(5'b11111 << len.nextra);

   always_comb begin
      result.status       = STAT_OK;
      result.result_value = 16'd0;
      result.match_length = 9'd0;
      take_n              = 5'd0;
      push_ok             = 1'b0;
      unique case (cmd_e)
         CMD_PUSH: begin
            if (fill_cur > PUSH_LIMIT) begin
               result.status = STAT_FULL;
            end else begin
               push_ok = 1'b1;
            end
         end
         CMD_DECODE: begin
            if (code_len == 4'd0) begin
               result.status = STAT_NEED_BITS;
            end else if (sym >= SYM_FIRST_INVALID) begin
               result.status       = STAT_INVALID;
               result.result_value = {7'b0, sym};
               take_n              = {1'b0, code_len};
            end else if (sym <= SYM_END_OF_BLOCK) begin
               result.result_value = {7'b0, sym};
               take_n              = {1'b0, code_len};
            end else if (fill_cur < FILL_W'(need)) begin
               result.status = STAT_NEED_BITS;
            end else begin
               result.result_value = {7'b0, sym};
               result.match_length = len.base + {4'b0, extra};
               take_n              = need;
            end
         end
         CMD_READ_LSB, CMD_READ_MSB: begin
            if (fill_cur < FILL_W'(cnt)) begin
               result.status = STAT_NEED_BITS;
            end else begin
               result.result_value = (cmd_e == CMD_READ_LSB) ? raw_lsb : raw_msb;
               take_n              = cnt;
            end
         end
         default: begin
            result.status = STAT_OK;
         end
      endcase
   end

   always_comb begin
      if (push_ok) begin
         buf_in  = buf_cur | (BUFFER_BITS'(item.data_byte) << fill_cur);
         fill_in = fill_cur + FILL_W'(8);
      end else begin
         buf_in  = buf_cur >> take_n;
         fill_in = fill_cur - FILL_W'(take_n);
      end
   end

endmodule

`default_nettype wire

/* design/fixed_huffman_symbol_decoder.sv */
// ---------------------------------------------------------------------------
// fixed_huffman_symbol_decoder
// Deflate bit reader with fixed-code literal/length symbol decoding.
// ---------------------------------------------------------------------------
// Takes one command per transfer on req_chan and returns exactly one result
// per command on rsp_chan, in order. Commands: push a byte into the bit
// buffer (LSB first), decode one fixed-Huffman literal/length symbol along
// with its length extra bits, or read 0..16 raw bits LSB-first or MSB-first.
// A command that cannot finish with the bits held reports "need bits" and
// consumes nothing; a push into a full buffer is refused with "buffer full".
// A request is captured in the input register; the command logic executes
// it when the result register is free or its result is being taken, and
// loads the result there. Throughput is one command per clock while the
// receiver keeps ready high. These two registers bracket the command logic,
// which reads and updates the bit buffer in the same cycle, so each command
// sees the buffer left by the one before it. BUFFER_BITS sets the buffer
// size (24..64); bits_held reports the fill modulo 64.
// ---------------------------------------------------------------------------
`default_nettype none

`include "fixed_huffman_symbol_decoder_assert.svh"

module fixed_huffman_symbol_decoder
   import fhsd_pkg::*;
#(
   parameter int BUFFER_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   fhsd_req_if.sink       req_chan,
   fhsd_rsp_if.source     rsp_chan
);

   localparam int FILL_W = $clog2(BUFFER_BITS+1);

   // input stage
   logic                    in_valid_ff, in_valid_in;
   fhsd_item_type           in_item_ff,  in_item_in;

   // bit buffer state
   logic [BUFFER_BITS-1:0]  buf_ff,  buf_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;

   // result stage
   logic                    out_valid_ff, out_valid_in;
   fhsd_result_type         out_res_ff,   out_res_in;
   logic [5:0]              out_held_ff,  out_held_in;

   fhsd_result_type         core_res;
   logic [BUFFER_BITS-1:0]  core_buf;
   logic [FILL_W-1:0]       core_fill;
   logic                    advance;
   logic                    req_xfer;

   fhsd_core #(
      .BUFFER_BITS (BUFFER_BITS)
   ) u_core (
      .item     (in_item_ff),
      .buf_cur  (buf_ff),
      .fill_cur (fill_ff),
      .result   (core_res),
      .buf_in   (core_buf),
      .fill_in  (core_fill)
   );

   // the held command executes whenever the result register is free or
   // its result is being taken this cycle
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      buf_in       = buf_ff;
      fill_in      = fill_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      out_held_in  = out_held_ff;

      // drop the result once it has been taken
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      // execute: commit buffer state and load the result register
      if (advance) begin
         in_valid_in  = 1'b0;
         buf_in       = core_buf;
         fill_in      = core_fill;
         out_valid_in = 1'b1;
         out_res_in   = core_res;
         out_held_in  = 6'(core_fill);
      end

      // capture a new command behind the one that advances
      if (req_xfer) begin
         in_valid_in          = 1'b1;
         in_item_in.cmd       = req_chan.cmd;
         in_item_in.data_byte = req_chan.data_byte;
         in_item_in.bit_count = req_chan.bit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         buf_ff       <= '0;
         fill_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         buf_ff       <= buf_in;
         fill_ff      <= fill_in;
      end
      in_item_ff  <= in_item_in;
      out_res_ff  <= out_res_in;
      out_held_ff <= out_held_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_res_ff.status;
   assign rsp_chan.result_value = out_res_ff.result_value;
   assign rsp_chan.match_length = out_res_ff.match_length;
   assign rsp_chan.bits_held    = out_held_ff;

   // fill never passes the buffer size
   `FHSD_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(BUFFER_BITS))

   // bits at or above the fill level stay zero
   `FHSD_ASSERT_ALWAYS(a_clean_top, clock, reset, (buf_ff >> fill_ff) == '0)

   // an accepted push grows the fill by one byte
   `FHSD_ASSERT_NEXT(a_push_grows, clock, reset,
      advance && core_res.status == STAT_OK && in_item_ff.cmd == CMD_PUSH,
      fill_ff == $past(fill_ff) + FILL_W'(8))

   // refused or short commands leave the buffer untouched
   `FHSD_ASSERT_NEXT(a_refuse_holds, clock, reset,
      advance && (core_res.status == STAT_NEED_BITS || core_res.status == STAT_FULL),
      $stable(fill_ff) && $stable(buf_ff))

   // reported fill matches the buffer state after the command
   `FHSD_ASSERT_IMPLY(a_held_match, clock, reset, out_valid_ff && !in_valid_ff,
      out_held_ff == 6'(fill_ff))

endmodule

`default_nettype wire

/* tb/fixed_huffman_symbol_decoder_test.sv */
// ---------------------------------------------------------------------------
// fixed_huffman_symbol_decoder_test
// Self-checking bench for the deflate bit reader and fixed-code decoder.
// ---------------------------------------------------------------------------
// Commands go in over the request channel and results come back over the
// response channel. A scoreboard keeps its own copy of the bit buffer and
// fill count, works out the result of every accepted command, and compares
// each response transfer with the oldest pending one. Stimulus is a short
// directed run, then well-formed streams of encoded symbols and raw reads
// with random content, then random noise, then a quiet well-formed run.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_huffman_symbol_decoder_test;
   import fhsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FILL_LIMIT = 32;

   typedef struct {
      fhsd_status_type status;
      logic [15:0]     value;
      logic [8:0]      match_len;
      logic [5:0]      held;
   } decoder_result_type;

   // one command of a well-formed stream and the bits it takes
   typedef struct {
      fhsd_cmd_type cmd;
      logic [4:0]   count;
      int unsigned  bits;
   } planned_op_type;

   // Track the bit buffer and predict the result of every accepted command.
   class bit_reader_scoreboard;
      logic [63:0]        held_bits;
      int unsigned        held_count;
      fhsd_status_type    last_status;
      decoder_result_type expected_results[$];
      int unsigned        errors;

      function new();
         held_bits  = '0;
         held_count = 0;
         errors     = 0;
      endfunction

      // first stream bit lands in the most significant position
      function int unsigned peek_first_msb(int unsigned n);
         int unsigned v;
         v = 0;
         for (int i = 0; i < n && i < 16; i++)
            v = (v << 1) | int'(held_bits[i]);
         return v;
      endfunction

      function void drop_bits(int unsigned n);
         held_bits  = held_bits >> n;
         held_count = (n > held_count) ? 0 : held_count - n;
      endfunction

      function void note_command(fhsd_cmd_type cmd, logic [7:0] data, logic [4:0] count);
         decoder_result_type r;
         int unsigned        n, code, codelen, sym, nextra, base;
         r.status    = STAT_OK;
         r.value     = '0;
         r.match_len = '0;
         n           = (count > 16) ? 16 : count;
         case (cmd)
            CMD_PUSH: begin
               if (held_count + 8 > FILL_LIMIT) begin
                  r.status = STAT_FULL;
               end else begin
                  held_bits  = held_bits | (64'(data) << held_count);
                  held_count = held_count + 8;
               end
            end
            CMD_DECODE: begin
               codelen = 0;
               sym     = 0;
               if (held_count < 7) begin
                  r.status = STAT_NEED_BITS;
               end else begin
                  code = peek_first_msb(7);
                  if (code < 24) begin
                     codelen = 7;
                     sym     = code + 256;
                  end else if (held_count >= 8) begin
                     code = peek_first_msb(8);
                     if (code < 192) begin
                        codelen = 8;
                        sym     = code - 48;
                     end else if (code < 200) begin
                        codelen = 8;
                        sym     = code + 88;
                     end else if (held_count >= 9) begin
                        codelen = 9;
                        sym     = peek_first_msb(9) - 256;
                     end
                  end
                  if (codelen == 0) begin
                     r.status = STAT_NEED_BITS;
                  end else if (sym >= 286) begin
                     r.status = STAT_INVALID;
                     r.value  = 16'(sym);
                     drop_bits(codelen);
                  end else if (sym <= 256) begin
                     r.value = 16'(sym);
                     drop_bits(codelen);
                  end else begin
                     // length symbols: base length and extra-bit count
                     if (sym == 285) begin
                        nextra = 0; base = 258;
                     end else if (sym < 265) begin
                        nextra = 0; base = sym - 254;
                     end else if (sym < 269) begin
                        nextra = 1; base = 11 + (sym - 265) * 2;
                     end else if (sym < 273) begin
                        nextra = 2; base = 19 + (sym - 269) * 4;
                     end else if (sym < 277) begin
                        nextra = 3; base = 35 + (sym - 273) * 8;
                     end else if (sym < 281) begin
                        nextra = 4; base = 67 + (sym - 277) * 16;
                     end else begin
                        nextra = 5; base = 131 + (sym - 281) * 32;
                     end
                     if (held_count < codelen + nextra) begin
                        r.status = STAT_NEED_BITS;
                     end else begin
                        r.value     = 16'(sym);
                        r.match_len = 9'(base +
                           int'((held_bits >> codelen) & ((64'd1 << nextra) - 1)));
                        drop_bits(codelen + nextra);
                     end
                  end
               end
            end
            default: begin
               if (held_count < n) begin
                  r.status = STAT_NEED_BITS;
               end else begin
                  if (cmd == CMD_READ_LSB)
                     r.value = 16'(held_bits & ((64'd1 << n) - 1));
                  else
                     r.value = 16'(peek_first_msb(n));
                  drop_bits(n);
               end
            end
         endcase
         r.held      = 6'(held_count);
         last_status = r.status;
         expected_results.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic [15:0] value,
                                 logic [8:0] match_len, logic [5:0] held);
         decoder_result_type want;
         if (expected_results.size() == 0) begin
            $error("result transfer with no command outstanding");
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, value);
            errors++;
         end
         if (match_len !== want.match_len) begin
            $error("match_length: expected %0d, got %0d", want.match_len, match_len);
            errors++;
         end
         if (held !== want.held) begin
            $error("bits_held: expected %0d, got %0d", want.held, held);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fhsd_req_if req_chan ();
   fhsd_rsp_if rsp_chan ();

   fixed_huffman_symbol_decoder #(
      .BUFFER_BITS(FILL_LIMIT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bit_reader_scoreboard sb;
   bit                   idle_on;          // random idle bursts on both sides
   bit                   rx_hold_request;  // ask the receiver for one long stall
   int unsigned          items_sent;
   bit                   stream_bits[$];   // encoded bits not yet pushed
   planned_op_type       planned_ops[$];   // commands that consume those bits

   always #1 clock = ~clock;

   // Check every response transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result(rsp_chan.status, rsp_chan.result_value,
                         rsp_chan.match_length, rsp_chan.bits_held);
   end

   // Receiver: accept by default, drop ready in random bursts, and hold off
   // once for a long stretch so the pipeline backs up into the request side.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Offer one command and hold it until the transfer happens.
   task automatic send_command(fhsd_cmd_type cmd, logic [7:0] data, logic [4:0] count);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.data_byte <= data;
      req_chan.bit_count <= count;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_command(cmd, data, count);
      items_sent++;
   endtask

   // Append the fixed code of a symbol (first code bit first) and its extra
   // bits (LSB first), and plan the decode that takes them.
   task automatic plan_symbol(int unsigned sym, logic [4:0] extra);
      int unsigned len, nx;
      logic [8:0]  code;
      if (sym < 144) begin
         len = 8; code = 9'(sym + 48);
      end else if (sym < 256) begin
         len = 9; code = 9'(sym + 256);
      end else if (sym < 280) begin
         len = 7; code = 9'(sym - 256);
      end else begin
         len = 8; code = 9'(sym - 88);
      end
      nx = (sym >= 265 && sym <= 284) ? (sym - 261) / 4 : 0;
      for (int i = len - 1; i >= 0; i--)
         stream_bits.push_back(code[i]);
      for (int i = 0; i < nx; i++)
         stream_bits.push_back(extra[i]);
      planned_ops.push_back('{CMD_DECODE, 5'($urandom_range(0, 31)), len + nx});
   endtask

   // Append random raw bits and plan the read that takes them.
   task automatic plan_read(fhsd_cmd_type cmd, logic [4:0] count);
      int unsigned n;
      n = (count > 16) ? 16 : count;
      for (int i = 0; i < n; i++)
         stream_bits.push_back(bit'($urandom_range(0, 1)));
      planned_ops.push_back('{cmd, count, n});
   endtask

   task automatic plan_random_token();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         plan_symbol($urandom_range(0, 255), '0);
      else if (pick < 45)
         plan_symbol(SYM_END_OF_BLOCK, '0);
      else if (pick < 80)
         plan_symbol($urandom_range(257, 285), 5'($urandom_range(0, 31)));
      else if (pick < 84)
         plan_symbol($urandom_range(286, 287), '0);
      else
         plan_read($urandom_range(0, 1) ? CMD_READ_LSB : CMD_READ_MSB,
                   5'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(0, 16)));
   endtask

   // Play the planned stream: push bytes while there is room, and issue the
   // next command when its bits are in (now and then too early, on purpose).
   // With refill set, keep planning random tokens until last_item.
   task automatic play_stream(int unsigned last_item, bit refill, int unsigned early_pct);
      logic [7:0] b;
      bit         can_push, op_ready, issue;
      while (items_sent < last_item && (refill || planned_ops.size() > 0)) begin
         while (refill && stream_bits.size() < 24)
            plan_random_token();
         can_push = stream_bits.size() >= 8 && sb.held_count + 8 <= FILL_LIMIT;
         op_ready = sb.held_count >= planned_ops[0].bits;
         issue    = !can_push || (op_ready ? ($urandom_range(0, 2) == 0)
                                           : ($urandom_range(0, 99) < early_pct));
         if (issue) begin
            send_command(planned_ops[0].cmd, 8'($urandom_range(0, 255)),
                         planned_ops[0].count);
            // a refused command consumed nothing, so retry it later
            if (sb.last_status != STAT_NEED_BITS)
               void'(planned_ops.pop_front());
         end else begin
            for (int i = 0; i < 8; i++)
               b[i] = stream_bits.pop_front();
            send_command(CMD_PUSH, b, 5'($urandom_range(0, 31)));
         end
      end
   endtask

   task automatic wait_for_results();
      while (sb.expected_results.size() > 0)
         @(posedge clock);
   endtask

   // Hard stop in case the block hangs.
   initial begin
      #200000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      sb                  = new();
      idle_on             = 1'b1;
      rx_hold_request     = 1'b0;
      items_sent          = 0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= CMD_PUSH;
      req_chan.data_byte <= '0;
      req_chan.bit_count <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty buffer: decode and over-long read want bits, zero-bit read is fine
      send_command(CMD_DECODE, 8'h00, 5'd0);
      send_command(CMD_READ_LSB, 8'hFF, 5'd0);
      send_command(CMD_READ_MSB, 8'h00, 5'd31);
      // fill the buffer to the top, then one more push is refused
      send_command(CMD_PUSH, 8'h00, 5'd31);
      send_command(CMD_PUSH, 8'hFF, 5'd0);
      send_command(CMD_PUSH, 8'hA5, 5'd31);
      send_command(CMD_PUSH, 8'h5A, 5'd0);
      send_command(CMD_PUSH, 8'h81, 5'd16);
      // saturated count reads 16 bits, then the rest MSB-first
      send_command(CMD_READ_LSB, 8'h00, 5'd31);
      send_command(CMD_READ_MSB, 8'hFF, 5'd16);

      // end of block, 8- and 9-bit literals, lengths with no, one and the
      // most extra bits, the longest match, and an invalid code
      plan_symbol(SYM_END_OF_BLOCK, '0);
      plan_symbol(0, '0);
      plan_symbol(255, '0);
      plan_symbol(265, 5'd1);
      plan_symbol(284, 5'd31);
      plan_symbol(285, '0);
      plan_symbol(287, '0);
      // round the stream up to whole bytes so the buffer ends empty
      if (stream_bits.size() % 8 != 0)
         plan_read(CMD_READ_MSB, 5'(8 - stream_bits.size() % 8));
      play_stream(1000, 1'b0, 0);

      // well-formed streams with random content; stall the receiver midway
      play_stream(150, 1'b1, 15);
      rx_hold_request = 1'b1;
      play_stream(270, 1'b1, 15);

      // noise: any command, any byte, any count
      while (items_sent < 370)
         send_command(fhsd_cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      5'($urandom_range(0, 31)));

      // empty the buffer to get back in step with a fresh stream
      while (sb.held_count > 0)
         send_command(CMD_READ_LSB, 8'($urandom_range(0, 255)),
                      5'((sb.held_count > 16) ? 16 : sb.held_count));
      stream_bits.delete();
      planned_ops.delete();

      // pause the sender until every result is back
      req_chan.valid <= 1'b0;
      wait_for_results();

      // last stretch at full rate on both sides
      idle_on = 1'b0;
      play_stream(items_sent + 80, 1'b1, 10);

      req_chan.valid <= 1'b0;
      wait_for_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/fhsd_pkg.sv
design/fhsd_if.sv
design/fhsd_core.sv
design/fixed_huffman_symbol_decoder.sv
tb/fixed_huffman_symbol_decoder_test.sv
